>>> rtl/core/bphc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphc_pkg
// Shared types and codes of the button press/hold classifier.
// ----------------------------------------------------------------------------
package bphc_pkg;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_RELEASED = 2'd1,
        EV_PRESSED  = 2'd2,
        EV_HELD     = 2'd3
    } bphc_event_t;

    // Report modes; the unused code behaves as state repeat
    localparam logic [1:0] MODE_STATE_REPEAT  = 2'd0;
    localparam logic [1:0] MODE_WAIT_HOLD     = 2'd1;
    localparam logic [1:0] MODE_WAIT_RELEASE  = 2'd2;

    // Register indexes
    localparam int unsigned REG_IDX_BITS = 3;
    typedef logic [REG_IDX_BITS-1:0] bphc_reg_idx_t;
    localparam bphc_reg_idx_t REG_ANALOG_MODE      = 3'd0;
    localparam bphc_reg_idx_t REG_ACTIVE_HIGH      = 3'd1;
    localparam bphc_reg_idx_t REG_ANALOG_THRESHOLD = 3'd2;
    localparam bphc_reg_idx_t REG_HOLD_TIME_MS     = 3'd3;
    localparam bphc_reg_idx_t REG_REPORT_MODE      = 3'd4;
    localparam bphc_reg_idx_t REG_REPEAT_MASK      = 3'd5;

    // Narrow control settings handed from the register file to the classifier
    typedef struct packed {
        logic       analog_mode;
        logic       active_high;
        logic [1:0] report_mode;
        logic [2:0] repeat_mask;
    } bphc_ctrl_t;

endpackage

>>> rtl/core/bphc_poll_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphc_poll_if
// Poll channel: pin level, converter sample and millisecond timestamp.
// ----------------------------------------------------------------------------
interface bphc_poll_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32
);
    logic                   valid;
    logic                   ready;
    logic                   digital_level;
    logic [SAMPLE_BITS-1:0] analog_sample;
    logic [TIME_BITS-1:0]   now_ms;

    modport source (output valid, output digital_level, output analog_sample,
                    output now_ms, input ready);
    modport sink   (input valid, input digital_level, input analog_sample,
                    input now_ms, output ready);
endinterface

>>> rtl/core/bphc_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphc_event_if
// Result channel: one classified button event per beat.
// ----------------------------------------------------------------------------
interface bphc_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] button_event;

    modport source (output valid, output button_event, input ready);
    modport sink   (input valid, input button_event, output ready);
endinterface

>>> rtl/core/button_press_hold_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_hold_classifier
// Classifies button polls as released, pressed or held and reports events.
// ----------------------------------------------------------------------------
// Usage:
//   poll   : valid/ready sink; each beat carries the pin level, a converter
//            sample and a free-running millisecond timestamp.
//   result : valid/ready source; exactly one beat per poll, carrying the
//            button event (none, released, pressed, held).
//   APB    : settings (input select, polarity, threshold, hold time, report
//            mode, repeat mask); write them only while no poll is in flight.
// The poll is captured in the poll register when accepted, then the classifier
// writes the result register, which drives the result beat.
// Throughput is one poll per cycle while the receiver does not stall; the single
// path is a timestamp subtract and compare against the hold time followed by the report-mode filter.
// Reset clears the press timer, the last reported state and the pending
// hold flag and loads the register defaults.
// A stalled receiver holds the result register; the poll register keeps
// one more beat and poll.ready falls only when both stages are full.
// ----------------------------------------------------------------------------
module button_press_hold_classifier #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 12,
    parameter int DATA_BITS   = (TIME_BITS > 32) ? 64 : 32,
    parameter int ADDR_BITS   = (TIME_BITS > 32) ? 6 : 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bphc_poll_if.sink            poll,
    bphc_event_if.source         result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);
    bphc_pkg::bphc_ctrl_t   ctrl;
    logic [SAMPLE_BITS-1:0] threshold;
    logic [TIME_BITS-1:0]   hold_time;

    // Poll register
    logic                   poll_valid_reg;
    logic                   level_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [TIME_BITS-1:0]   now_reg;

    // Result register
    logic                   result_valid_reg;
    bphc_pkg::bphc_event_t  result_event_reg;

    bphc_pkg::bphc_event_t  event_next;
    logic                   result_free;
    logic                   advance;
    logic                   poll_take;

    bphc_regs #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .DATA_BITS   (DATA_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .ctrl      (ctrl),
        .threshold (threshold),
        .hold_time (hold_time)
    );

    // Result register can take a beat when empty or being drained this cycle
    assign result_free = !result_valid_reg || result.ready;
    // Move the held poll through the classifier into the result register
    assign advance     = poll_valid_reg && result_free;
    assign poll.ready  = !poll_valid_reg || result_free;
    assign poll_take   = poll.valid && poll.ready;

    bphc_classify #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .digital_level (level_reg),
        .analog_sample (sample_reg),
        .now_ms        (now_reg),
        .ctrl          (ctrl),
        .threshold     (threshold),
        .hold_time     (hold_time),
        .button_event  (event_next)
    );

    // Poll stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poll_valid_reg <= 1'b0;
        else if (poll.ready)
            poll_valid_reg <= poll.valid;
    end

    // Poll payload: capture on an accepted beat
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            level_reg  <= poll.digital_level;
            sample_reg <= poll.analog_sample;
            now_reg    <= poll.now_ms;
        end
    end

    // Result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_free)
            result_valid_reg <= poll_valid_reg;
    end

    // Result payload: hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (advance)
            result_event_reg <= event_next;
    end

    assign result.valid        = result_valid_reg;
    assign result.button_event = result_event_reg;
endmodule

>>> rtl/core/bphc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphc_regs
// APB-style register file holding the classifier settings.
// ----------------------------------------------------------------------------
module bphc_regs #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32,
    parameter int DATA_BITS   = 32,
    parameter int ADDR_BITS   = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready,
    output bphc_pkg::bphc_ctrl_t   ctrl,
    output logic [SAMPLE_BITS-1:0] threshold,
    output logic [TIME_BITS-1:0]   hold_time
);
    localparam int STRIDE_LOG2 = (DATA_BITS > 32) ? 3 : 2;

    bphc_pkg::bphc_ctrl_t   ctrl_reg;
    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [TIME_BITS-1:0]   hold_time_reg;
    bphc_pkg::bphc_reg_idx_t idx;
    logic                   wr_en;

    assign idx    = paddr[STRIDE_LOG2 +: bphc_pkg::REG_IDX_BITS];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.analog_mode   <= 1'b0;
            ctrl_reg.active_high   <= 1'b1;
            ctrl_reg.report_mode   <= bphc_pkg::MODE_STATE_REPEAT;
            ctrl_reg.repeat_mask   <= 3'b000;
            threshold_reg          <= SAMPLE_BITS'(2048);
            hold_time_reg          <= TIME_BITS'(1000);
        end
        else if (wr_en)
        begin
            unique case (idx)
                bphc_pkg::REG_ANALOG_MODE:      ctrl_reg.analog_mode   <= pwdata[0];
                bphc_pkg::REG_ACTIVE_HIGH:      ctrl_reg.active_high   <= pwdata[0];
                bphc_pkg::REG_ANALOG_THRESHOLD: threshold_reg <= pwdata[SAMPLE_BITS-1:0];
                bphc_pkg::REG_HOLD_TIME_MS:     hold_time_reg <= pwdata[TIME_BITS-1:0];
                bphc_pkg::REG_REPORT_MODE:      ctrl_reg.report_mode   <= pwdata[1:0];
                bphc_pkg::REG_REPEAT_MASK:      ctrl_reg.repeat_mask   <= pwdata[2:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            bphc_pkg::REG_ANALOG_MODE:      prdata[0] = ctrl_reg.analog_mode;
            bphc_pkg::REG_ACTIVE_HIGH:      prdata[0] = ctrl_reg.active_high;
            bphc_pkg::REG_ANALOG_THRESHOLD: prdata[SAMPLE_BITS-1:0] = threshold_reg;
            bphc_pkg::REG_HOLD_TIME_MS:     prdata[TIME_BITS-1:0] = hold_time_reg;
            bphc_pkg::REG_REPORT_MODE:      prdata[1:0] = ctrl_reg.report_mode;
            bphc_pkg::REG_REPEAT_MASK:      prdata[2:0] = ctrl_reg.repeat_mask;
            default:                        prdata = '0;
        endcase
    end

    assign ctrl      = ctrl_reg;
    assign threshold = threshold_reg;
    assign hold_time = hold_time_reg;
endmodule

>>> rtl/core/bphc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphc_classify
// Press timing state and report-mode filter; state advances once per poll.
// ----------------------------------------------------------------------------
module bphc_classify #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   digital_level,
    input  logic [SAMPLE_BITS-1:0] analog_sample,
    input  logic [TIME_BITS-1:0]   now_ms,
    input  bphc_pkg::bphc_ctrl_t   ctrl,
    input  logic [SAMPLE_BITS-1:0] threshold,
    input  logic [TIME_BITS-1:0]   hold_time,
    output bphc_pkg::bphc_event_t  button_event
);
    logic [TIME_BITS-1:0]  press_start_reg, press_start_next;
    logic                  timing_active_reg, timing_active_next;
    bphc_pkg::bphc_event_t previous_state_reg, previous_state_next;
    logic                  hold_pending_reg, hold_pending_next;

    logic                  active;
    logic [TIME_BITS-1:0]  elapsed;
    bphc_pkg::bphc_event_t raw;
    bphc_pkg::bphc_event_t rep_event;
    logic                  rep_mask_bit;

    always_comb
    begin
        if (ctrl.analog_mode)
            active = ctrl.active_high ? (analog_sample >= threshold)
                                      : (analog_sample <= threshold);
        else
            active = ctrl.active_high ? digital_level : !digital_level;
    end

    assign elapsed = now_ms - press_start_reg;

    // Raw state and press timing
    always_comb
    begin
        press_start_next   = press_start_reg;
        timing_active_next = timing_active_reg;
        if (active)
        begin
            raw = bphc_pkg::EV_PRESSED;
            if (!timing_active_reg)
            begin
                timing_active_next = 1'b1;
                press_start_next   = now_ms;
            end
            else if (elapsed >= hold_time)
                raw = bphc_pkg::EV_HELD;
        end
        else
        begin
            raw                = bphc_pkg::EV_RELEASED;
            timing_active_next = 1'b0;
            press_start_next   = '0;
        end
    end

    // State-repeat view of the raw state, shared by two modes
    always_comb
    begin
        unique case (raw)
            bphc_pkg::EV_RELEASED: rep_mask_bit = ctrl.repeat_mask[0];
            bphc_pkg::EV_PRESSED:  rep_mask_bit = ctrl.repeat_mask[1];
            bphc_pkg::EV_HELD:     rep_mask_bit = ctrl.repeat_mask[2];
            default:               rep_mask_bit = 1'b0;
        endcase
        if (raw != previous_state_reg)
            rep_event = raw;
        else
            rep_event = rep_mask_bit ? raw : bphc_pkg::EV_NONE;
    end

    always_comb
    begin
        previous_state_next = previous_state_reg;
        hold_pending_next   = hold_pending_reg;
        button_event        = bphc_pkg::EV_NONE;
        priority if (ctrl.report_mode == bphc_pkg::MODE_WAIT_RELEASE)
        begin
            previous_state_next = raw;
            button_event = (raw == bphc_pkg::EV_RELEASED) ? previous_state_reg
                                                          : bphc_pkg::EV_NONE;
        end
        else if (ctrl.report_mode == bphc_pkg::MODE_WAIT_HOLD
                 && raw == bphc_pkg::EV_PRESSED)
        begin
            hold_pending_next = 1'b1;
        end
        else if (ctrl.report_mode == bphc_pkg::MODE_WAIT_HOLD
                 && hold_pending_reg && raw == bphc_pkg::EV_RELEASED)
        begin
            hold_pending_next = 1'b0;
            button_event      = bphc_pkg::EV_PRESSED;
        end
        else
        begin
            // Wait-hold when held or released with no pending press, or plain state repeat
            if (ctrl.report_mode == bphc_pkg::MODE_WAIT_HOLD)
                hold_pending_next = 1'b0;
            previous_state_next = raw;
            button_event        = rep_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_start_reg    <= '0;
            timing_active_reg  <= 1'b0;
            previous_state_reg <= bphc_pkg::EV_NONE;
            hold_pending_reg   <= 1'b0;
        end
        else if (step)
        begin
            press_start_reg    <= press_start_next;
            timing_active_reg  <= timing_active_next;
            previous_state_reg <= previous_state_next;
            hold_pending_reg   <= hold_pending_next;
        end
    end
endmodule
